FILE: rtl/alr_pkg.sv
// ----------------------------------------------------------------------------
// alr_pkg
// Types, reset values and small helpers of the linear resampler.
// ----------------------------------------------------------------------------
package alr_pkg;

  localparam int MaxOuts   = 64;
  localparam int DivSteps  = 62;
  localparam int RateW     = 24;
  localparam int GainW     = 36;
  localparam int PhaseW    = 26;
  localparam int ScaledW   = 54;

  localparam logic [RateW-1:0] OutRateReset = 24'd12288000;
  localparam logic [RateW-1:0] InRateReset  = 24'd12288000;
  localparam logic [GainW-1:0] GainReset    = 36'h1_0000_0000;

  typedef enum logic [2:0] {
    CFG_OUT_RATE      = 3'd0,
    CFG_IN_RATE       = 3'd1,
    CFG_GAIN          = 3'd2,
    CFG_SAMPLE_16BIT  = 3'd3,
    CFG_SAMPLE_SIGNED = 3'd4,
    CFG_SOURCE_STEREO = 3'd5,
    CFG_OUTPUT_STEREO = 3'd6
  } cfg_idx_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCALE = 8'b0000_0010,
    ST_DIFF  = 8'b0000_0100,
    ST_PROD  = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_VAL   = 8'b0010_0000,
    ST_CONV  = 8'b0100_0000,
    ST_PUSH  = 8'b1000_0000
  } state_t;

  // Raw code to signed sample value.
  function automatic logic signed [15:0] decode(input logic [15:0] raw,
                                                input logic is16,
                                                input logic twos);
    logic signed [15:0] v;
    begin
      if (is16) begin
        v = twos ? raw : {~raw[15], raw[14:0]};
      end else begin
        v = twos ? {{8{raw[7]}}, raw[7:0]} : {{8{~raw[7]}}, ~raw[7], raw[6:0]};
      end
      return v;
    end
  endfunction

  // Sign and magnitude to saturated int16.
  function automatic logic [15:0] sat16(input logic neg, input logic [16:0] mag);
    logic [15:0] o;
    begin
      if (neg) begin
        o = (mag > 17'd32768) ? 16'h8000 : 16'(17'd0 - mag);
      end else begin
        o = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
      end
      return o;
    end
  endfunction

endpackage

FILE: rtl/audio_linear_resampler_unit.sv
// ----------------------------------------------------------------------------
// audio_linear_resampler_unit
// Linear interpolation sample rate converter with gain and mono mixdown.
// ----------------------------------------------------------------------------
// Source frames enter on s_axis (tdata = left_raw, right_raw); output frames
// leave on m_axis (tdata = left_out, right_out; tlast marks the final result
// of a frame, tuser flags an overrun). Registers are written through
// cfg_we / cfg_index / cfg_data; the user must write them only while the
// block is idle, as the block itself does not enforce it. One 24x24
// multiplier and one 25-bit restoring divide step are shared under the
// sequencer. Per active channel (one in mono output, two in stereo output)
// a frame goes through gain scaling, a difference, then two rounds of
// product and divide steps before the first result. Every result then
// passes through interpolate, convert and transfer. s_axis_tready is high
// only while idle; a frame with no result returns to idle after setup.
// Results sit in an output register, so a new frame can be accepted while
// the last result still waits. A stalled receiver holds the sequencer in its
// transfer step. Reset restores the register defaults, clears the sample
// history and phase, and drops any pending result.
// ----------------------------------------------------------------------------
module audio_linear_resampler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] left_raw, [31:16] right_raw
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] left_out, [31:16] right_out
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser,   // [0] overrun
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [35:0] cfg_data
);

  alr_pkg::state_t state;

  logic [23:0] out_rate;
  logic [23:0] in_rate;
  logic [35:0] gain;
  logic        sample_16bit;
  logic        sample_signed;
  logic        source_stereo;
  logic        output_stereo;

  logic signed [53:0] cur  [2];
  logic signed [53:0] prev [2];
  logic signed [25:0] phase;

  logic [16:0]        smag  [2];
  logic               sneg  [2];
  logic signed [37:0] pbase [2];
  logic               dneg  [2];
  logic [39:0]        q     [2];
  logic [23:0]        r     [2];
  logic [39:0]        qa    [2];
  logic [23:0]        ra    [2];
  logic [39:0]        vv    [2];
  logic [16:0]        tmag  [2];
  logic               tneg  [2];

  logic               ch;
  logic               pass;
  logic [5:0]         cnt;
  logic [5:0]         n;
  logic [47:0]        prod;
  logic [61:0]        acc;
  logic [23:0]        rem;
  logic signed [38:0] dd;
  logic [37:0]        dmag;

  logic [23:0]        orate;
  logic [23:0]        irate;
  logic signed [25:0] phase_plus;
  logic signed [25:0] phase_new;
  logic [23:0]        mul_a;
  logic [23:0]        mul_b;
  logic [47:0]        mul_out;
  logic [61:0]        prod_sh;
  logic [25:0]        trial;
  logic               qbit;
  logic [23:0]        rem_next;
  logic [61:0]        acc_next;
  logic signed [15:0] dl;
  logic signed [15:0] dr;
  logic signed [16:0] samp0;
  logic signed [16:0] samp1;
  logic signed [37:0] cur_sh;
  logic signed [37:0] prev_sh;
  logic [39:0]        val_next [2];
  logic [39:0]        q_next   [2];
  logic [23:0]        r_next   [2];
  logic [24:0]        rsum     [2];
  logic [25:0]        rdiff    [2];
  logic [39:0]        neg_v    [2];
  logic [24:0]        ceil_sum [2];
  logic               push;
  logic               last_out;
  logic               over_out;

  assign orate = (out_rate == '0) ? 24'd1 : out_rate;
  assign irate = (in_rate == '0) ? 24'd1 : in_rate;
  assign phase_plus = phase + $signed({2'b00, orate});
  assign phase_new  = phase + $signed({2'b00, irate});

  assign s_axis_tready = (state == alr_pkg::ST_IDLE);
  assign push = (state == alr_pkg::ST_PUSH) && (!m_axis_tvalid || m_axis_tready);
  assign last_out = !phase_new[25] || (n == 6'(alr_pkg::MaxOuts - 1));
  assign over_out = phase_new[25] && (n == 6'(alr_pkg::MaxOuts - 1));

  always_comb begin
    dl = alr_pkg::decode(s_axis_tdata[15:0], sample_16bit, sample_signed);
    dr = source_stereo ? alr_pkg::decode(s_axis_tdata[31:16], sample_16bit, sample_signed)
                       : dl;
    samp1 = 17'(dr);
    samp0 = output_stereo ? 17'(dl) : 17'(dl) + 17'(dr);
  end

  always_comb begin
    if (state == alr_pkg::ST_SCALE) begin
      mul_a = {7'd0, smag[ch]};
      mul_b = (cnt == 6'd0) ? gain[23:0] : {12'd0, gain[35:24]};
    end else begin
      mul_a = pass ? irate : phase_plus[23:0];
      mul_b = (cnt == 6'd0) ? dmag[23:0] : {10'd0, dmag[37:24]};
    end
    mul_out = mul_a * mul_b;
    prod_sh = {prod[37:0], 24'd0};
  end

  always_comb begin
    trial    = {1'b0, rem, acc[61]} - {2'b00, orate};
    qbit     = !trial[25];
    rem_next = qbit ? trial[23:0] : {rem[22:0], acc[61]};
    acc_next = {acc[60:0], qbit};
    cur_sh   = cur[ch][53:16];
    prev_sh  = prev[ch][53:16];
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      val_next[c] = dneg[c] ? {{2{pbase[c][37]}}, pbase[c]} - q[c]
                            : {{2{pbase[c][37]}}, pbase[c]} + q[c];
      rsum[c]     = {1'b0, r[c]} + {1'b0, ra[c]};
      rdiff[c]    = {1'b0, rsum[c]} - {2'b00, orate};
      r_next[c]   = rdiff[c][25] ? rsum[c][23:0] : rdiff[c][23:0];
      q_next[c]   = q[c] + qa[c] + {39'd0, !rdiff[c][25]};
      neg_v[c]    = 40'd0 - vv[c];
      ceil_sum[c] = {1'b0, neg_v[c][39:16]} + 25'd255;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_rate      <= alr_pkg::OutRateReset;
      in_rate       <= alr_pkg::InRateReset;
      gain          <= alr_pkg::GainReset;
      sample_16bit  <= 1'b1;
      sample_signed <= 1'b1;
      source_stereo <= 1'b0;
      output_stereo <= 1'b0;
    end else if (cfg_we) begin
      case (alr_pkg::cfg_idx_t'(cfg_index))
        alr_pkg::CFG_OUT_RATE:      out_rate      <= cfg_data[23:0];
        alr_pkg::CFG_IN_RATE:       in_rate       <= cfg_data[23:0];
        alr_pkg::CFG_GAIN:          gain          <= cfg_data;
        alr_pkg::CFG_SAMPLE_16BIT:  sample_16bit  <= cfg_data[0];
        alr_pkg::CFG_SAMPLE_SIGNED: sample_signed <= cfg_data[0];
        alr_pkg::CFG_SOURCE_STEREO: source_stereo <= cfg_data[0];
        alr_pkg::CFG_OUTPUT_STEREO: output_stereo <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= alr_pkg::ST_IDLE;
      cur[0]        <= '0;
      cur[1]        <= '0;
      prev[0]       <= '0;
      prev[1]       <= '0;
      phase         <= '0;
      ch            <= 1'b0;
      pass          <= 1'b0;
      cnt           <= '0;
      n             <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (push) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        alr_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            smag[0] <= samp0[16] ? 17'(17'd0 - samp0) : samp0;
            sneg[0] <= samp0[16];
            smag[1] <= samp1[16] ? 17'(17'd0 - samp1) : samp1;
            sneg[1] <= samp1[16];
            prev[0] <= cur[0];
            if (output_stereo) begin
              prev[1] <= cur[1];
            end
            phase <= phase - $signed({2'b00, orate});
            ch    <= 1'b0;
            cnt   <= '0;
            n     <= '0;
            state <= alr_pkg::ST_SCALE;
          end
        end
        alr_pkg::ST_SCALE: begin
          cnt <= cnt + 6'd1;
          case (cnt)
            6'd0: prod <= mul_out;
            6'd1: begin
              acc  <= {14'd0, prod};
              prod <= mul_out;
            end
            6'd2: acc <= acc + prod_sh;
            default: begin
              cur[ch] <= sneg[ch] ? 54'(54'd0 - acc[53:0]) : acc[53:0];
              cnt     <= '0;
              state   <= alr_pkg::ST_DIFF;
            end
          endcase
        end
        alr_pkg::ST_DIFF: begin
          if (cnt == 6'd0) begin
            dd        <= {cur_sh[37], cur_sh} - {prev_sh[37], prev_sh};
            pbase[ch] <= prev_sh;
            cnt       <= 6'd1;
          end else begin
            dmag     <= dd[38] ? 38'(39'd0 - dd) : dd[37:0];
            dneg[ch] <= dd[38];
            pass     <= 1'b0;
            cnt      <= '0;
            state    <= alr_pkg::ST_PROD;
          end
        end
        alr_pkg::ST_PROD: begin
          cnt <= cnt + 6'd1;
          case (cnt)
            6'd0: prod <= mul_out;
            6'd1: begin
              acc  <= {14'd0, prod};
              prod <= mul_out;
            end
            default: begin
              acc   <= acc + prod_sh;
              rem   <= '0;
              cnt   <= '0;
              state <= alr_pkg::ST_DIV;
            end
          endcase
        end
        alr_pkg::ST_DIV: begin
          acc <= acc_next;
          rem <= rem_next;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(alr_pkg::DivSteps - 1)) begin
            cnt <= '0;
            if (!pass) begin
              q[ch] <= acc_next[39:0];
              r[ch] <= rem_next;
              pass  <= 1'b1;
              state <= alr_pkg::ST_PROD;
            end else begin
              qa[ch] <= acc_next[39:0];
              ra[ch] <= rem_next;
              if (ch != output_stereo) begin
                ch    <= 1'b1;
                state <= alr_pkg::ST_SCALE;
              end else begin
                state <= phase[25] ? alr_pkg::ST_VAL : alr_pkg::ST_IDLE;
              end
            end
          end
        end
        alr_pkg::ST_VAL: begin
          for (int c = 0; c < 2; c++) begin
            vv[c] <= val_next[c];
            q[c]  <= q_next[c];
            r[c]  <= r_next[c];
          end
          state <= alr_pkg::ST_CONV;
        end
        alr_pkg::ST_CONV: begin
          for (int c = 0; c < 2; c++) begin
            tneg[c] <= vv[c][39];
            tmag[c] <= vv[c][39] ? ceil_sum[c][24:8] : {1'b0, vv[c][39:24]};
          end
          state <= alr_pkg::ST_PUSH;
        end
        alr_pkg::ST_PUSH: begin
          if (push) begin
            phase <= over_out ? 26'sd0 : phase_new;
            n     <= n + 6'd1;
            state <= last_out ? alr_pkg::ST_IDLE : alr_pkg::ST_VAL;
          end
        end
        default: state <= alr_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_axis_tdata[15:0]  <= alr_pkg::sat16(tneg[0], tmag[0]);
      m_axis_tdata[31:16] <= output_stereo ? alr_pkg::sat16(tneg[1], tmag[1]) : 16'd0;
      m_axis_tlast        <= last_out;
      m_axis_tuser        <= over_out;
    end
  end

endmodule

FILE: tb/sv/tb_audio_linear_resampler_unit.sv
// ----------------------------------------------------------------------------
// tb_audio_linear_resampler_unit
// Self-checking bench for the linear interpolation resampler.
// ----------------------------------------------------------------------------
// Source frames are fed on s_axis from a queue and each transfer runs through
// a bit-exact resampler model. The model pushes the output frames it
// predicts, and each output transfer is compared against the oldest one.
// The run starts with a short directed set: code extremes, saturation, 8-bit
// offset binary, overrun, zero rates, frames with no output and zero gain.
// After that come randomized register settings with random frames. Both
// handshakes idle at random, with one stretch that has no idling. Registers
// are only written after the output has drained and the block is idle.
// ----------------------------------------------------------------------------
module tb_audio_linear_resampler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
    logic        overrun;
  } out_frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [35:0] cfg_data = '0;

  // register copies and sample history of the model
  logic [alr_pkg::RateW-1:0]          out_rate_r = alr_pkg::OutRateReset;
  logic [alr_pkg::RateW-1:0]          in_rate_r  = alr_pkg::InRateReset;
  logic [alr_pkg::GainW-1:0]          gain_r     = alr_pkg::GainReset;
  logic                               is16_r     = 1'b1;
  logic                               signed_r   = 1'b1;
  logic                               src_st_r   = 1'b0;
  logic                               out_st_r   = 1'b0;
  logic signed [alr_pkg::ScaledW-1:0] cur_l = '0, cur_r = '0, prev_l = '0, prev_r = '0;
  logic signed [alr_pkg::PhaseW-1:0]  acc_phase = '0;

  logic [31:0] feed[$];
  out_frame_t  forecast[$];
  logic        steady = 1'b0;
  int          errors = 0;
  int          frames_in = 0;
  int          frames_out = 0;
  int          overruns = 0;
  int          settings = 0;
  int unsigned audio_hz[7] = '{8000, 11025, 16000, 22050, 32000, 44100, 48000};

  audio_linear_resampler_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint sample_value(input logic [15:0] raw);
    if (is16_r) begin
      return signed_r ? longint'($signed(raw)) : longint'(raw) - 32768;
    end
    return signed_r ? longint'($signed(raw[7:0])) : longint'(raw[7:0]) - 128;
  endfunction

  function automatic logic [15:0] blend(input longint prev, input longint cur,
                                        input longint frac, input longint rate);
    longint p, c, v, m, o;
    p = prev >>> 16;
    c = cur >>> 16;
    v = p + ((c - p) * frac) / rate;
    m = v / 65536;
    o = m >>> 8;
    if (o < -32768) o = -32768;
    if (o > 32767) o = 32767;
    return o[15:0];
  endfunction

  task automatic resample_frame(input logic [31:0] raw);
    longint     orate, irate, g, l, r, ph, nxt, frac, sl, sr;
    int         n;
    out_frame_t f;
    orate = (out_rate_r == 0) ? 1 : longint'(out_rate_r);
    irate = (in_rate_r == 0) ? 1 : longint'(in_rate_r);
    g = longint'(gain_r);
    l = sample_value(raw[15:0]);
    r = src_st_r ? sample_value(raw[31:16]) : l;
    prev_l = cur_l;
    if (out_st_r) begin
      prev_r = cur_r;
      sr = r * g;
      cur_r = sr[alr_pkg::ScaledW-1:0];
    end else begin
      l = l + r;
    end
    sl = l * g;
    cur_l = sl[alr_pkg::ScaledW-1:0];
    ph = longint'(acc_phase) - orate;
    n = 0;
    while (ph < 0 && n < alr_pkg::MaxOuts) begin
      frac = orate + ph;
      if (frac < 0) frac = 0;
      nxt = ph + irate;
      f.left = blend(prev_l, cur_l, frac, orate);
      f.right = out_st_r ? blend(prev_r, cur_r, frac, orate) : 16'h0000;
      f.last = (nxt >= 0) || (n == alr_pkg::MaxOuts - 1);
      f.overrun = (nxt < 0) && (n == alr_pkg::MaxOuts - 1);
      forecast.push_back(f);
      ph = nxt;
      n++;
    end
    if (ph < 0) ph = 0;
    acc_phase = ph[alr_pkg::PhaseW-1:0];
  endtask

  // source side
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        resample_frame(s_axis_tdata);
        frames_in++;
      end
      if (feed.size() != 0 && (steady || $urandom_range(0, 99) >= 22)) begin
        s_axis_tdata <= feed.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side
  always @(posedge clk) begin
    out_frame_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast, m_axis_tuser[0]};
        if (forecast.size() == 0) begin
          errors++;
          $display("%0t: unexpected output left=%0d right=%0d last=%0b overrun=%0b",
                   $time, $signed(got.left), $signed(got.right), got.last, got.overrun);
        end else begin
          want = forecast.pop_front();
          frames_out++;
          if (want.overrun) overruns++;
          if (got !== want) begin
            errors++;
            $display("%0t: expected l=%0d r=%0d last=%0b ovr=%0b, got l=%0d r=%0d last=%0b ovr=%0b",
                     $time, $signed(want.left), $signed(want.right), want.last,
                     want.overrun, $signed(got.left), $signed(got.right), got.last,
                     got.overrun);
          end
        end
      end
      m_axis_tready <= steady || $urandom_range(0, 99) >= 22;
    end
  end

  task automatic set_reg(input alr_pkg::cfg_idx_t idx, input logic [35:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      alr_pkg::CFG_OUT_RATE:      out_rate_r = val[alr_pkg::RateW-1:0];
      alr_pkg::CFG_IN_RATE:       in_rate_r = val[alr_pkg::RateW-1:0];
      alr_pkg::CFG_GAIN:          gain_r = val[alr_pkg::GainW-1:0];
      alr_pkg::CFG_SAMPLE_16BIT:  is16_r = val[0];
      alr_pkg::CFG_SAMPLE_SIGNED: signed_r = val[0];
      alr_pkg::CFG_SOURCE_STEREO: src_st_r = val[0];
      alr_pkg::CFG_OUTPUT_STEREO: out_st_r = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold the source until every output has drained, then let setup finish
  task automatic settle();
    do @(negedge clk);
    while (feed.size() != 0 || s_axis_tvalid || forecast.size() != 0);
    repeat (400) @(negedge clk);
    settings++;
  endtask

  task automatic random_setup();
    longint orate, irate;
    int     sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      orate = $urandom_range(1, 24'hFFFFFF);
      irate = $urandom_range(1, 24'hFFFFFF);
    end else if (sel <= 6) begin
      irate = $urandom_range(65536, 2097152);
      orate = irate * $urandom_range(1, 40) / 8;
    end else if (sel <= 8) begin
      orate = longint'(audio_hz[$urandom_range(0, 6)]) * 256;
      irate = longint'(audio_hz[$urandom_range(0, 6)]) * 256;
    end else begin
      orate = $urandom_range(16384, 24'hFFFFFF);
      irate = $urandom_range(1, 255);
    end
    set_reg(alr_pkg::CFG_OUT_RATE, 36'(orate));
    set_reg(alr_pkg::CFG_IN_RATE, 36'(irate));
    if ($urandom_range(0, 3) == 0) begin
      set_reg(alr_pkg::CFG_GAIN, {4'($urandom_range(0, 15)), 32'($urandom())});
    end else begin
      set_reg(alr_pkg::CFG_GAIN,
              36'h0_8000_0000 + 36'($urandom_range(0, 32'hFFFFFFFF)) * 2);
    end
    set_reg(alr_pkg::CFG_SAMPLE_16BIT, 36'($urandom_range(0, 1)));
    set_reg(alr_pkg::CFG_SAMPLE_SIGNED, 36'($urandom_range(0, 1)));
    set_reg(alr_pkg::CFG_SOURCE_STEREO, 36'($urandom_range(0, 1)));
    set_reg(alr_pkg::CFG_OUTPUT_STEREO, 36'($urandom_range(0, 1)));
  endtask

  function automatic logic [15:0] random_code();
    logic [15:0] edges[4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
    if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 3)];
    return 16'($urandom());
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 16-bit signed, mono, equal rates
    feed = '{32'h0000_0000, 32'h0000_7FFF, 32'h0000_8000, 32'hFFFF_FFFF, 32'h5A5A_A5A5};
    settle();

    // full gain, stereo in and out: saturate both ways
    set_reg(alr_pkg::CFG_GAIN, 36'hF_FFFF_FFFF);
    set_reg(alr_pkg::CFG_SOURCE_STEREO, 36'd1);
    set_reg(alr_pkg::CFG_OUTPUT_STEREO, 36'd1);
    feed = '{32'h8000_7FFF, 32'h7FFF_8000, 32'h0001_FFFF};
    settle();

    // 8-bit offset binary, upper byte ignored
    set_reg(alr_pkg::CFG_GAIN, 36'(alr_pkg::GainReset));
    set_reg(alr_pkg::CFG_SAMPLE_16BIT, 36'd0);
    set_reg(alr_pkg::CFG_SAMPLE_SIGNED, 36'd0);
    feed = '{32'hFF00_00FF, 32'h0080_FF7F, 32'h127F_AB80};
    settle();

    // fastest output against slowest input: every frame overruns
    set_reg(alr_pkg::CFG_OUT_RATE, 36'hFF_FFFF);
    set_reg(alr_pkg::CFG_IN_RATE, 36'd1);
    set_reg(alr_pkg::CFG_SAMPLE_SIGNED, 36'd1);
    feed = '{32'h0080_007F, 32'h00FF_0001};
    settle();

    // both rates zero act as one
    set_reg(alr_pkg::CFG_OUT_RATE, 36'd0);
    set_reg(alr_pkg::CFG_IN_RATE, 36'd0);
    feed = '{32'h00C3_003C, 32'h0000_0080};
    settle();

    // slow output: only the first frame produces a result, the rest produce nothing
    set_reg(alr_pkg::CFG_OUT_RATE, 36'd1);
    set_reg(alr_pkg::CFG_IN_RATE, 36'hFF_FFFF);
    set_reg(alr_pkg::CFG_SAMPLE_16BIT, 36'd1);
    set_reg(alr_pkg::CFG_OUTPUT_STEREO, 36'd0);
    feed = '{32'h1234_7FFF, 32'h8000_8000, 32'hFFFF_0001};
    settle();

    // zero gain
    set_reg(alr_pkg::CFG_OUT_RATE, 36'(alr_pkg::OutRateReset));
    set_reg(alr_pkg::CFG_IN_RATE, 36'(alr_pkg::InRateReset));
    set_reg(alr_pkg::CFG_GAIN, 36'd0);
    feed = '{32'h7FFF_7FFF};
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      random_setup();
      steady = (ph == 4);
      for (int i = 0; i < 35; i++) feed.push_back({random_code(), random_code()});
      settle();
    end
    steady = 1'b0;

    $display("Checked %0d output frames (%0d overruns) from %0d source frames",
             frames_out, overruns, frames_in);
    $display("across %0d register settings with random handshake gaps.", settings);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out waiting for output frames.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: audio_linear_resampler_unit.f
rtl/alr_pkg.sv
rtl/audio_linear_resampler_unit.sv
tb/sv/tb_audio_linear_resampler_unit.sv
